FILE: hdl/slfc_pkg.sv
// shared types, decode constants and reset values for the leaf-function classifier
`timescale 1ns / 1ps

package slfc_pkg;

   // instruction word width and field layout
   localparam int unsigned INSTR_W  = 32;
   localparam int unsigned INDEX_W  = 32;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned DISP_W   = 22;

   // csr map: one register, byte address 4 * index
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic CSR_IDX_BRANCH_LIMIT = 1'b0;

   localparam logic [COUNT_W-1:0] BRANCH_LIMIT_RESET = 8'd10;

   // decode masks and match values
   localparam logic [INSTR_W-1:0] FMT3_MASK   = 32'h8100_0000;
   localparam logic [INSTR_W-1:0] FMT3_VAL    = 32'h8000_0000;
   localparam logic [INSTR_W-1:0] RET_WORD    = 32'h81c7_e008;
   localparam logic [INSTR_W-1:0] RETL_WORD   = 32'h81c3_e008;
   localparam logic [INSTR_W-1:0] SAVE_MASK   = 32'hc1f8_0000;
   localparam logic [INSTR_W-1:0] SAVE_VAL    = 32'h81e0_0000;
   localparam logic [INSTR_W-1:0] RESTORE_VAL = 32'h81e8_0000;
   localparam logic [INSTR_W-1:0] CALL_MASK   = 32'hc000_0000;
   localparam logic [INSTR_W-1:0] CALL_VAL    = 32'h4000_0000;
   localparam logic [INSTR_W-1:0] JMPL_MASK   = 32'h81f8_0000;
   localparam logic [INSTR_W-1:0] JMPL_VAL    = 32'h81c0_0000;
   localparam logic [INSTR_W-1:0] BA_MASK     = 32'hdfc0_0000;
   localparam logic [INSTR_W-1:0] BA_VAL      = 32'h1080_0000;
   localparam logic [4:0]         REG_O7      = 5'd15;

   typedef enum logic [1:0] {
      VERDICT_SCAN    = 2'd0,
      VERDICT_LEAF    = 2'd1,
      VERDICT_NONLEAF = 2'd2
   } verdict_type;

   // scan state carried from word to word
   typedef struct packed {
      logic               in_delay_slot;
      logic [COUNT_W-1:0] branches_followed;
      logic [INDEX_W-1:0] last_taken_index;
      logic [INDEX_W-1:0] scan_index;
   } scan_state_type;

   localparam scan_state_type SCAN_STATE_CLEAR = '{
      in_delay_slot:     1'b0,
      branches_followed: '0,
      last_taken_index:  '0,
      scan_index:        '0
   };

endpackage

FILE: hdl/slfc_decode.sv
// single-word decode and scan-state update for the leaf-function classifier
`timescale 1ns / 1ps

module slfc_decode (
   input  logic                               start_req,
   input  logic [slfc_pkg::INSTR_W-1:0]       instr,
   input  logic [slfc_pkg::COUNT_W-1:0]       branch_limit,
   input  slfc_pkg::scan_state_type           state_cur,
   output slfc_pkg::scan_state_type           state_next,
   output slfc_pkg::verdict_type              verdict,
   output logic [slfc_pkg::INDEX_W-1:0]       next_index
);

   slfc_pkg::scan_state_type   base;
   slfc_pkg::scan_state_type   upd;
   slfc_pkg::verdict_type      v;
   logic [slfc_pkg::INDEX_W-1:0] nxt;
   logic [slfc_pkg::INDEX_W-1:0] disp_ext;
   logic [slfc_pkg::COUNT_W-1:0] count_inc;
   logic [4:0]                   rs1;
   logic [4:0]                   rd;
   logic                         fall_through;

   // start flag clears the scan before this word
   assign base = start_req ? slfc_pkg::SCAN_STATE_CLEAR : state_cur;
   assign nxt  = base.scan_index + 32'd1;
   assign rs1  = instr[18:14];
   assign rd   = instr[29:25];
   assign count_inc = base.branches_followed + 8'd1;
   assign disp_ext  = {{(slfc_pkg::INDEX_W-slfc_pkg::DISP_W){instr[slfc_pkg::DISP_W-1]}},
                       instr[slfc_pkg::DISP_W-1:0]};

   // classify the word
   always_comb begin
      upd          = base;
      v            = slfc_pkg::VERDICT_SCAN;
      fall_through = 1'b0;
      if ((instr & slfc_pkg::FMT3_MASK) == slfc_pkg::FMT3_VAL) begin
         if (rs1[4] || rd[4]) begin
            v = slfc_pkg::VERDICT_NONLEAF;
         end else if ((instr & slfc_pkg::JMPL_MASK) == slfc_pkg::JMPL_VAL) begin
            upd.in_delay_slot = 1'b1;
            upd.scan_index    = nxt;
         end else if (rd == slfc_pkg::REG_O7) begin
            v = base.in_delay_slot ? slfc_pkg::VERDICT_LEAF : slfc_pkg::VERDICT_NONLEAF;
         end else begin
            fall_through = 1'b1;
         end
      end else begin
         if ((instr & slfc_pkg::CALL_MASK) == slfc_pkg::CALL_VAL) begin
            upd.in_delay_slot = 1'b1;
            upd.scan_index    = nxt;
         end else if (instr == slfc_pkg::RET_WORD) begin
            v = slfc_pkg::VERDICT_NONLEAF;
         end else if (instr == slfc_pkg::RETL_WORD) begin
            v = slfc_pkg::VERDICT_LEAF;
         end else if ((instr & slfc_pkg::BA_MASK) == slfc_pkg::BA_VAL) begin
            // follow the branch unless the limit hits or it repeats
            upd.branches_followed = count_inc;
            if (count_inc == branch_limit || base.last_taken_index == nxt) begin
               v = slfc_pkg::VERDICT_NONLEAF;
            end else begin
               upd.last_taken_index = nxt;
               upd.scan_index       = base.scan_index + disp_ext;
            end
         end else if ((instr & slfc_pkg::SAVE_MASK) == slfc_pkg::SAVE_VAL) begin
            v = slfc_pkg::VERDICT_LEAF;
         end else if ((instr & slfc_pkg::SAVE_MASK) == slfc_pkg::RESTORE_VAL) begin
            v = slfc_pkg::VERDICT_NONLEAF;
         end else begin
            fall_through = 1'b1;
         end
      end
      // unclassified word: non-leaf inside a delay slot, else step on
      if (fall_through) begin
         if (base.in_delay_slot) begin
            v = slfc_pkg::VERDICT_NONLEAF;
         end else begin
            upd.scan_index = nxt;
         end
      end
   end

   // a verdict ends the scan and restarts at index 0
   assign verdict    = v;
   assign state_next = (v == slfc_pkg::VERDICT_SCAN) ? upd : slfc_pkg::SCAN_STATE_CLEAR;
   assign next_index = state_next.scan_index;

endmodule

FILE: hdl/sparc_leaf_function_classifier.sv
// top level: csr port, scan state, result register and checks
// an accepted request beat is answered by its response beat in the next cycle
// throughput: one instruction word per cycle while req_stall is low, set by the
//   combinational decode and scan-state update that feeds the response register
// req_stall rises only while a response beat is held by rsp_stall
// reset clears the scan state, the response valid and sets branch_limit to 10
`timescale 1ns / 1ps

module sparc_leaf_function_classifier (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_start_req,
   input  logic [slfc_pkg::INSTR_W-1:0]        req_instr,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_verdict,
   output logic signed [slfc_pkg::INDEX_W-1:0] rsp_next_index,
   // csr port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [slfc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [slfc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [slfc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [slfc_pkg::COUNT_W-1:0] branch_limit_ff;
   logic [slfc_pkg::COUNT_W-1:0] branch_limit_in;
   slfc_pkg::scan_state_type     scan_ff;
   slfc_pkg::scan_state_type     scan_in;
   slfc_pkg::scan_state_type     scan_dec;
   slfc_pkg::verdict_type        verdict_dec;
   logic [slfc_pkg::INDEX_W-1:0] index_dec;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [1:0]                   verdict_ff;
   logic [slfc_pkg::INDEX_W-1:0] index_ff;
   logic                         req_accept;
   logic                         csr_write;

   // csr access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == slfc_pkg::CSR_IDX_BRANCH_LIMIT) ?
                       {{(slfc_pkg::CSR_DATA_W-slfc_pkg::COUNT_W){1'b0}}, branch_limit_ff} :
                       '0;
   assign branch_limit_in = (csr_write && csr_paddr[2] == slfc_pkg::CSR_IDX_BRANCH_LIMIT) ?
                            csr_pwdata[slfc_pkg::COUNT_W-1:0] : branch_limit_ff;

   // beat handshake: hold off only while a response is stuck
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   slfc_decode u_decode (
      .start_req    (req_start_req),
      .instr        (req_instr),
      .branch_limit (branch_limit_ff),
      .state_cur    (scan_ff),
      .state_next   (scan_dec),
      .verdict      (verdict_dec),
      .next_index   (index_dec)
   );

   // next state and response valid
   assign scan_in      = req_accept ? scan_dec : scan_ff;
   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         branch_limit_ff <= slfc_pkg::BRANCH_LIMIT_RESET;
         scan_ff         <= slfc_pkg::SCAN_STATE_CLEAR;
         rsp_valid_ff    <= 1'b0;
      end else begin
         branch_limit_ff <= branch_limit_in;
         scan_ff         <= scan_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         verdict_ff <= verdict_dec;
         index_ff   <= index_dec;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_verdict    = verdict_ff;
   assign rsp_next_index = index_ff;

   // checks
   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted request beat did not produce a response beat");

   a_verdict_restarts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_verdict != slfc_pkg::VERDICT_SCAN) |-> rsp_next_index == '0)
      else $error("final verdict without restart at index 0");

   a_state_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(req_accept)) |-> $stable(scan_ff))
      else $error("scan state changed without an accepted beat");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled with no held response");

endmodule
